// ===== src/ordered_request_window_queue_defines.svh =====
// Assertion macros shared by the ordered request window queue RTL.
// Standalone header, no dependencies; included by the top level only.
`ifndef ORDERED_REQUEST_WINDOW_QUEUE_DEFINES_SVH
`define ORDERED_REQUEST_WINDOW_QUEUE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ORWQ_ASSERT_NOW(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Implication with a fixed number of cycles between cause and effect.
`define ORWQ_ASSERT_LATER(label, clk, rst, pre, n, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> ##n (post)) \
      else $error(msg);

`endif

// ===== src/orwq_pkg.sv =====
// Shared types and constants for the ordered request window queue.
// No dependencies; used by orwq_front, orwq_back and the top level.
package orwq_pkg;

   // Parameter defaults
   localparam int MAX_NODES_DEFAULT   = 16;
   localparam int STAMP_WIDTH_DEFAULT = 32;

   // Fixed field widths
   localparam int FUNC_W      = 2;
   localparam int NODE_W      = 4;
   localparam int REQ_STAMP_W = 32;
   localparam int ERR_W       = 2;
   localparam int LEN_W       = 5;
   localparam int RES_W       = 8;

   // Resource count ceiling
   localparam logic [RES_W-1:0] RES_MAX = 8'd255;

   // Depth of the command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Event kinds
   typedef enum logic [FUNC_W-1:0] {
      FUNC_REQUEST = 2'd0,
      FUNC_CONSUME = 2'd1,
      FUNC_PRODUCE = 2'd2,
      FUNC_NONE    = 2'd3
   } func_code_type;

   // Result error codes
   typedef enum logic [ERR_W-1:0] {
      ERR_OK      = 2'd0,
      ERR_DUP     = 2'd1,
      ERR_FULL    = 2'd2,
      ERR_CONSUME = 2'd3
   } err_code_type;

   // Classified command handed from front to back
   typedef struct packed {
      func_code_type     kind;
      logic              node_ok;
      logic [NODE_W-1:0] node;
   } cmd_type;

endpackage

// ===== src/ordered_request_window_queue.sv =====
// Ordered request window queue, top level: front end, command queue, back end.
// Depends on orwq_pkg, orwq_front, orwq_back and the defines header.
//
// Keeps requests sorted by stamp (ties to the lower node id) with a grant
// window as wide as the resource count. Every accepted word (start high while
// busy is low) yields exactly one result, shown for a single cycle with
// rsp_valid; the receiver cannot stall it, so it must take every result as it
// comes. Into an empty block, a word passes the command queue, the compare
// stage and the result registers in turn. The back end works on a word in two
// steps (compare against every entry, then shift and update) and takes no new
// word until the last is applied; a two-word queue in front lets start be
// taken while the back end is working, and busy rises only when that queue is
// full. Write csr_write_data with csr_write_en only while no word is in flight;
// it reloads the window count at once. No clearing pass is needed after reset.
module ordered_request_window_queue #(
   parameter int MAX_NODES   = orwq_pkg::MAX_NODES_DEFAULT,
   parameter int STAMP_WIDTH = orwq_pkg::STAMP_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [orwq_pkg::FUNC_W-1:0]       req_func,
   input  logic [orwq_pkg::NODE_W-1:0]       req_node_id,
   input  logic [orwq_pkg::REQ_STAMP_W-1:0]  req_stamp,
   output logic                              rsp_valid,
   output logic                              rsp_grant_valid,
   output logic [orwq_pkg::NODE_W-1:0]       rsp_grant_id,
   output logic [orwq_pkg::ERR_W-1:0]        rsp_error_code,
   output logic [orwq_pkg::LEN_W-1:0]        rsp_queue_length,
   output logic [orwq_pkg::RES_W-1:0]        rsp_resources_left,
   input  logic                              csr_write_en,
   input  logic [orwq_pkg::RES_W-1:0]        csr_write_data
);
   import orwq_pkg::*;
`include "ordered_request_window_queue_defines.svh"

   logic                   head_valid;
   cmd_type                head_cmd;
   logic [STAMP_WIDTH-1:0] head_stamp;
   logic                   pop;
   logic                   stage_busy;

   orwq_front #(
      .MAX_NODES   (MAX_NODES),
      .STAMP_WIDTH (STAMP_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_func    (req_func),
      .req_node_id (req_node_id),
      .req_stamp   (req_stamp),
      .busy        (busy),
      .head_valid  (head_valid),
      .head_cmd    (head_cmd),
      .head_stamp  (head_stamp),
      .pop         (pop)
   );

   orwq_back #(
      .MAX_NODES   (MAX_NODES),
      .STAMP_WIDTH (STAMP_WIDTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_cmd           (head_cmd),
      .head_stamp         (head_stamp),
      .pop                (pop),
      .stage_busy         (stage_busy),
      .csr_write_en       (csr_write_en),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_grant_valid    (rsp_grant_valid),
      .rsp_grant_id       (rsp_grant_id),
      .rsp_error_code     (rsp_error_code),
      .rsp_queue_length   (rsp_queue_length),
      .rsp_resources_left (rsp_resources_left)
   );

   // A failed event never grants
   `ORWQ_ASSERT_NOW(a_err_no_grant, clock, reset, rsp_valid && (rsp_error_code != ERR_OK), !rsp_grant_valid, "grant reported on a failed event")

   // Queue never reports more entries than it can hold
   `ORWQ_ASSERT_NOW(a_len_bound, clock, reset, rsp_valid, 32'(rsp_queue_length) <= 32'(MAX_NODES), "queue length beyond capacity")

   // Into an empty block, an accepted word yields its result without stalling
   `ORWQ_ASSERT_LATER(a_empty_latency, clock, reset, start && !busy && !head_valid && !stage_busy, 3, rsp_valid, "result missing after accept into empty block")

   // The back end only pulls from a non-empty queue while its stage is free
   `ORWQ_ASSERT_NOW(a_pop_legal, clock, reset, pop, head_valid && !stage_busy, "pop from empty queue or busy stage")

endmodule

// ===== src/orwq_front.sv =====
// Front end: accepts words, classifies them and holds them in a short queue.
// Depends on orwq_pkg.
module orwq_front #(
   parameter int MAX_NODES   = orwq_pkg::MAX_NODES_DEFAULT,
   parameter int STAMP_WIDTH = orwq_pkg::STAMP_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [orwq_pkg::FUNC_W-1:0]        req_func,
   input  logic [orwq_pkg::NODE_W-1:0]        req_node_id,
   input  logic [orwq_pkg::REQ_STAMP_W-1:0]   req_stamp,
   output logic                               busy,
   output logic                               head_valid,
   output orwq_pkg::cmd_type                  head_cmd,
   output logic [STAMP_WIDTH-1:0]             head_stamp,
   input  logic                               pop
);
   import orwq_pkg::*;

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type                q_cmd_ff   [QUEUE_DEPTH];
   cmd_type                q_cmd_in   [QUEUE_DEPTH];
   logic [STAMP_WIDTH-1:0] q_stamp_ff [QUEUE_DEPTH];
   logic [STAMP_WIDTH-1:0] q_stamp_in [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   cmd_type                cls_cmd;
   logic                   push;

   // Classify the incoming word
   always_comb begin
      cls_cmd.kind    = func_code_type'(req_func);
      cls_cmd.node    = req_node_id;
      cls_cmd.node_ok = (32'(req_node_id) < 32'(MAX_NODES));
   end

   assign busy       = (count_ff == COUNT_W'(QUEUE_DEPTH));
   assign push       = start && !busy;
   assign head_valid = (count_ff != '0);
   assign head_cmd   = q_cmd_ff[rd_ptr_ff];
   assign head_stamp = q_stamp_ff[rd_ptr_ff];

   // Queue pointers and storage
   always_comb begin
      q_cmd_in   = q_cmd_ff;
      q_stamp_in = q_stamp_ff;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      count_in   = count_ff;
      if (push) begin
         q_cmd_in[wr_ptr_ff]   = cls_cmd;
         q_stamp_in[wr_ptr_ff] = STAMP_WIDTH'(req_stamp);
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      q_cmd_ff   <= q_cmd_in;
      q_stamp_ff <= q_stamp_in;
   end

endmodule

// ===== src/orwq_back.sv =====
// Back end: sorted entry row, acknowledged marks and window count; compares
// a command against every entry, then applies it and registers the result.
// Depends on orwq_pkg.
module orwq_back #(
   parameter int MAX_NODES   = orwq_pkg::MAX_NODES_DEFAULT,
   parameter int STAMP_WIDTH = orwq_pkg::STAMP_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          head_valid,
   input  orwq_pkg::cmd_type             head_cmd,
   input  logic [STAMP_WIDTH-1:0]        head_stamp,
   output logic                          pop,
   output logic                          stage_busy,
   input  logic                          csr_write_en,
   input  logic [orwq_pkg::RES_W-1:0]    csr_write_data,
   output logic                          rsp_valid,
   output logic                          rsp_grant_valid,
   output logic [orwq_pkg::NODE_W-1:0]   rsp_grant_id,
   output logic [orwq_pkg::ERR_W-1:0]    rsp_error_code,
   output logic [orwq_pkg::LEN_W-1:0]    rsp_queue_length,
   output logic [orwq_pkg::RES_W-1:0]    rsp_resources_left
);
   import orwq_pkg::*;

   localparam int TOTAL_W = $clog2(MAX_NODES + 1);

   // Entry row and bookkeeping
   logic [NODE_W-1:0]      node_ff [MAX_NODES];
   logic [NODE_W-1:0]      node_in [MAX_NODES];
   logic [STAMP_WIDTH-1:0] time_ff [MAX_NODES];
   logic [STAMP_WIDTH-1:0] time_in [MAX_NODES];
   logic [TOTAL_W-1:0]     total_ff, total_in;
   logic [MAX_NODES-1:0]   mark_ff, mark_in;
   logic [RES_W-1:0]       wc_ff, wc_in, wc_evt;

   // Compare stage
   logic                   stage_valid_ff, stage_valid_in;
   cmd_type                stage_cmd_ff, stage_cmd_in;
   logic [STAMP_WIDTH-1:0] stage_stamp_ff, stage_stamp_in;
   logic [MAX_NODES-1:0]   match_ff, match_in;
   logic [MAX_NODES-1:0]   before_ff, before_in;
   logic [NODE_W-1:0]      prod_node_ff, prod_node_in;
   logic                   prod_hit_ff, prod_hit_in;

   // Result registers
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   grant_valid_ff, grant_valid_in;
   logic [NODE_W-1:0]      grant_id_ff, grant_id_in;
   err_code_type           err_ff, err_in;
   logic [LEN_W-1:0]       len_ff, len_in;
   logic [RES_W-1:0]       res_ff, res_in;

   // Apply-cycle decode
   logic [MAX_NODES-1:0]   after_p;
   logic [MAX_NODES-1:0]   win_edge;
   logic [MAX_NODES-1:0]   in_win;
   logic [MAX_NODES-1:0]   node_hot;
   logic [MAX_NODES-1:0]   prod_hot;
   logic                   found, full, ins_in_win, cons_in_win;
   logic                   node_marked, prod_marked;
   logic                   do_insert, do_remove;

   assign pop        = head_valid && !stage_valid_ff;
   assign stage_busy = stage_valid_ff;

   // Compare the head command against every entry
   always_comb begin
      stage_valid_in = pop;
      stage_cmd_in   = stage_cmd_ff;
      stage_stamp_in = stage_stamp_ff;
      match_in       = match_ff;
      before_in      = before_ff;
      prod_node_in   = '0;
      prod_hit_in    = prod_hit_ff;
      if (pop) begin
         stage_cmd_in   = head_cmd;
         stage_stamp_in = head_stamp;
         prod_hit_in    = (32'(wc_ff) < 32'(total_ff));
         for (int i = 0; i < MAX_NODES; i++) begin
            match_in[i]  = (32'(i) < 32'(total_ff)) && (node_ff[i] == head_cmd.node);
            before_in[i] = (32'(i) < 32'(total_ff)) &&
                           ((time_ff[i] < head_stamp) ||
                            ((time_ff[i] == head_stamp) && (node_ff[i] < head_cmd.node)));
         end
      end
      // entry sitting just past the current window
      for (int i = 0; i < MAX_NODES; i++) begin
         if (32'(i) == 32'(wc_ff)) begin
            prod_node_in = prod_node_in | node_ff[i];
         end
      end
      if (!pop) begin
         prod_node_in = prod_node_ff;
      end
   end

   // Window and mark lookups for the command in the apply cycle
   always_comb begin
      for (int i = 0; i < MAX_NODES; i++) begin
         after_p[i] = 1'b0;
         for (int j = 0; j <= i; j++) begin
            after_p[i] = after_p[i] | match_ff[j];
         end
         win_edge[i] = (32'(wc_ff) == 32'(i) + 32'd1);
         in_win[i]   = (32'(i) < 32'(wc_ff));
         node_hot[i] = (32'(stage_cmd_ff.node) == 32'(i));
         prod_hot[i] = (32'(prod_node_ff) == 32'(i));
      end
      found       = |match_ff;
      full        = (32'(total_ff) >= 32'(MAX_NODES));
      ins_in_win  = (wc_ff != '0) && !(|(before_ff & win_edge));
      cons_in_win = |(match_ff & in_win);
      node_marked = |(mark_ff & node_hot);
      prod_marked = |(mark_ff & prod_hot);
   end

   // Apply the command
   always_comb begin
      node_in        = node_ff;
      time_in        = time_ff;
      total_in       = total_ff;
      mark_in        = mark_ff;
      wc_evt         = wc_ff;
      do_insert      = 1'b0;
      do_remove      = 1'b0;
      grant_valid_in = 1'b0;
      grant_id_in    = '0;
      err_in         = ERR_OK;

      if (stage_valid_ff) begin
         case (stage_cmd_ff.kind)
            FUNC_REQUEST: begin
               if (!stage_cmd_ff.node_ok) begin
                  err_in = ERR_FULL;
               end else if (found) begin
                  err_in = ERR_DUP;
               end else if (full) begin
                  err_in = ERR_FULL;
               end else begin
                  do_insert = 1'b1;
                  total_in  = total_ff + 1'b1;
                  if (ins_in_win) begin
                     grant_valid_in = 1'b1;
                     grant_id_in    = stage_cmd_ff.node;
                     mark_in        = mark_ff | node_hot;
                  end
               end
            end
            FUNC_CONSUME: begin
               if (!stage_cmd_ff.node_ok || !found || !cons_in_win || !node_marked) begin
                  err_in = ERR_CONSUME;
               end else begin
                  do_remove = 1'b1;
                  total_in  = total_ff - 1'b1;
                  mark_in   = mark_ff & ~node_hot;
                  wc_evt    = wc_ff - 1'b1;
               end
            end
            FUNC_PRODUCE: begin
               if (wc_ff != RES_MAX) begin
                  wc_evt = wc_ff + 1'b1;
                  if (prod_hit_ff && !prod_marked) begin
                     grant_valid_in = 1'b1;
                     grant_id_in    = prod_node_ff;
                     mark_in        = mark_ff | prod_hot;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      // shift-insert: entries ranked after the new one move up a place
      if (do_insert) begin
         if (!before_ff[0]) begin
            node_in[0] = stage_cmd_ff.node;
            time_in[0] = stage_stamp_ff;
         end
         for (int i = 1; i < MAX_NODES; i++) begin
            if (!before_ff[i]) begin
               if (before_ff[i-1]) begin
                  node_in[i] = stage_cmd_ff.node;
                  time_in[i] = stage_stamp_ff;
               end else begin
                  node_in[i] = node_ff[i-1];
                  time_in[i] = time_ff[i-1];
               end
            end
         end
      end

      // remove: entries from the consumed one onward move down a place
      if (do_remove) begin
         for (int i = 0; i < MAX_NODES - 1; i++) begin
            if (after_p[i]) begin
               node_in[i] = node_ff[i+1];
               time_in[i] = time_ff[i+1];
            end
         end
      end

      // a register write reloads the window count
      wc_in = csr_write_en ? csr_write_data : wc_evt;

      rsp_valid_in = stage_valid_ff;
      len_in       = LEN_W'(total_in);
      res_in       = wc_evt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff       <= '0;
         mark_ff        <= '0;
         wc_ff          <= '0;
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         total_ff       <= total_in;
         mark_ff        <= mark_in;
         wc_ff          <= wc_in;
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff        <= node_in;
      time_ff        <= time_in;
      stage_cmd_ff   <= stage_cmd_in;
      stage_stamp_ff <= stage_stamp_in;
      match_ff       <= match_in;
      before_ff      <= before_in;
      prod_node_ff   <= prod_node_in;
      prod_hit_ff    <= prod_hit_in;
      grant_valid_ff <= grant_valid_in;
      grant_id_ff    <= grant_id_in;
      err_ff         <= err_in;
      len_ff         <= len_in;
      res_ff         <= res_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_grant_valid    = grant_valid_ff;
   assign rsp_grant_id       = grant_id_ff;
   assign rsp_error_code     = err_ff;
   assign rsp_queue_length   = len_ff;
   assign rsp_resources_left = res_ff;

endmodule

// ===== dv/ordered_request_window_queue_tb.sv =====
// Testbench for ordered_request_window_queue: directed and random words checked
// against an in-bench model of the sorted queue, grant window and ack marks.
// Depends on orwq_pkg and the ordered_request_window_queue RTL only.
`timescale 1ns / 1ps

module ordered_request_window_queue_tb;
   import orwq_pkg::*;

   localparam int NODES = 16;
   localparam int SETTLE_CYCLES = 12;

   // One event word and the result it produces
   typedef struct {
      func_code_type func;
      logic [NODE_W-1:0] node;
      logic [REQ_STAMP_W-1:0] stamp;
   } event_word_type;

   typedef struct {
      logic grant_valid;
      logic [NODE_W-1:0] grant_id;
      err_code_type error_code;
      logic [LEN_W-1:0] queue_length;
      logic [RES_W-1:0] resources_left;
   } outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [FUNC_W-1:0] req_func = '0;
   logic [NODE_W-1:0] req_node_id = '0;
   logic [REQ_STAMP_W-1:0] req_stamp = '0;
   logic rsp_valid;
   logic rsp_grant_valid;
   logic [NODE_W-1:0] rsp_grant_id;
   logic [ERR_W-1:0] rsp_error_code;
   logic [LEN_W-1:0] rsp_queue_length;
   logic [RES_W-1:0] rsp_resources_left;
   logic csr_write_en = 1'b0;
   logic [RES_W-1:0] csr_write_data = '0;

   ordered_request_window_queue dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_func(req_func),
      .req_node_id(req_node_id),
      .req_stamp(req_stamp),
      .rsp_valid(rsp_valid),
      .rsp_grant_valid(rsp_grant_valid),
      .rsp_grant_id(rsp_grant_id),
      .rsp_error_code(rsp_error_code),
      .rsp_queue_length(rsp_queue_length),
      .rsp_resources_left(rsp_resources_left),
      .csr_write_en(csr_write_en),
      .csr_write_data(csr_write_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Model state: sorted entries, ack marks, window size
   logic [NODE_W-1:0] held_node [NODES];
   logic [REQ_STAMP_W-1:0] held_stamp [NODES];
   int held_total = 0;
   bit acked [NODES];
   int window_size = 0;

   event_word_type pending_words [$];
   outcome_type awaited_outcomes [$];
   event_word_type word_on_bus;
   logic word_taken = 1'b0;
   int idle_pct = 0;
   int mismatch_count = 0;

   // Apply one event to the model and return the result it should produce
   function automatic outcome_type advance_queue_state(event_word_type w);
      outcome_type o;
      int hit;
      int pos;
      o.grant_valid = 1'b0;
      o.grant_id = '0;
      o.error_code = ERR_OK;
      hit = -1;
      for (int i = 0; i < held_total; i++)
         if (held_node[i] == w.node) hit = i;
      case (w.func)
         FUNC_REQUEST: begin
            if (hit >= 0) begin
               o.error_code = ERR_DUP;
            end else if (held_total >= NODES) begin
               o.error_code = ERR_FULL;
            end else begin
               // stamp order, ties to the lower node id
               pos = 0;
               while (pos < held_total && (held_stamp[pos] < w.stamp ||
                      (held_stamp[pos] == w.stamp && held_node[pos] < w.node)))
                  pos++;
               for (int i = held_total; i > pos; i--) begin
                  held_node[i] = held_node[i-1];
                  held_stamp[i] = held_stamp[i-1];
               end
               held_node[pos] = w.node;
               held_stamp[pos] = w.stamp;
               held_total++;
               if (pos < window_size) begin
                  o.grant_valid = 1'b1;
                  o.grant_id = w.node;
                  acked[w.node] = 1'b1;
               end
            end
         end
         FUNC_CONSUME: begin
            if (hit < 0 || hit >= window_size || !acked[w.node]) begin
               o.error_code = ERR_CONSUME;
            end else begin
               for (int i = hit; i + 1 < held_total; i++) begin
                  held_node[i] = held_node[i+1];
                  held_stamp[i] = held_stamp[i+1];
               end
               held_total--;
               acked[w.node] = 1'b0;
               window_size--;
            end
         end
         FUNC_PRODUCE: begin
            // saturated count: no change, no grant
            if (window_size < 255) begin
               window_size++;
               if (window_size - 1 < held_total && !acked[held_node[window_size-1]]) begin
                  o.grant_valid = 1'b1;
                  o.grant_id = held_node[window_size-1];
                  acked[held_node[window_size-1]] = 1'b1;
               end
            end
         end
         default: ;
      endcase
      o.queue_length = LEN_W'(held_total);
      o.resources_left = RES_W'(window_size);
      return o;
   endfunction

   // Random word shaped by the current model state
   function automatic event_word_type pick_random_word();
      event_word_type w;
      int r;
      int free_nodes [$];
      int granted_nodes [$];
      bit present;
      r = $urandom_range(0, 99);
      w.node = NODE_W'($urandom_range(0, NODES - 1));
      w.stamp = $urandom;
      for (int n = 0; n < NODES; n++) begin
         present = 1'b0;
         for (int i = 0; i < held_total; i++)
            if (int'(held_node[i]) == n) present = 1'b1;
         if (!present) free_nodes.insert(free_nodes.size(), n);
      end
      for (int i = 0; i < held_total && i < window_size; i++)
         if (acked[held_node[i]])
            granted_nodes.insert(granted_nodes.size(), int'(held_node[i]));
      if (r < 40) begin
         w.func = FUNC_REQUEST;
         if (free_nodes.size() > 0 && $urandom_range(0, 9) < 8)
            w.node = NODE_W'(free_nodes[$urandom_range(0, free_nodes.size() - 1)]);
         // small stamps force ties
         case ($urandom_range(0, 9))
            0: w.stamp = '0;
            1: w.stamp = '1;
            2, 3, 4: w.stamp = $urandom_range(0, 7);
            default: ;
         endcase
      end else if (r < 70) begin
         w.func = FUNC_CONSUME;
         if (granted_nodes.size() > 0 && $urandom_range(0, 3) != 0)
            w.node = NODE_W'(granted_nodes[$urandom_range(0, granted_nodes.size() - 1)]);
      end else if (r < 94) begin
         w.func = FUNC_PRODUCE;
      end else begin
         w.func = FUNC_NONE;
      end
      return w;
   endfunction

   task automatic queue_word(func_code_type f, int node, logic [REQ_STAMP_W-1:0] stamp);
      event_word_type w;
      w.func = f;
      w.node = NODE_W'(node);
      w.stamp = stamp;
      pending_words.insert(pending_words.size(), w);
   endtask

   // Wait until no word is queued, in flight or awaiting its result
   task automatic wait_idle();
      while (pending_words.size() > 0 || start || awaited_outcomes.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_resources(logic [RES_W-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      window_size = int'(value);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic run_random(int count, int pct);
      idle_pct = pct;
      repeat (count) begin
         while (pending_words.size() > 1) @(posedge clock);
         pending_words.insert(pending_words.size(), pick_random_word());
      end
   endtask

   task automatic note_mismatch(string field, int expv, int actv);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch in %s: expected %0d, got %0d", field, expv, actv);
   endtask

   // Acceptance seen at the rising edge
   always @(posedge clock)
      word_taken <= !reset && start && !busy;

   // Driver: records accepted words, then offers the next one or idles
   always @(negedge clock) begin
      if (!reset) begin
         if (start && word_taken)
            awaited_outcomes.insert(awaited_outcomes.size(),
                                    advance_queue_state(word_on_bus));
         if (!start || word_taken) begin
            if (pending_words.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
               word_on_bus = pending_words.pop_front();
               req_func <= word_on_bus.func;
               req_node_id <= word_on_bus.node;
               req_stamp <= word_on_bus.stamp;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobed result against the oldest expectation
   always @(posedge clock) begin
      outcome_type e;
      if (!reset && rsp_valid) begin
         if (awaited_outcomes.size() == 0) begin
            note_mismatch("unexpected result, queue_length", -1, int'(rsp_queue_length));
         end else begin
            e = awaited_outcomes.pop_front();
            if (rsp_grant_valid !== e.grant_valid)
               note_mismatch("grant_valid", int'(e.grant_valid), int'(rsp_grant_valid));
            if (rsp_grant_id !== e.grant_id)
               note_mismatch("grant_id", int'(e.grant_id), int'(rsp_grant_id));
            if (rsp_error_code !== e.error_code)
               note_mismatch("error_code", int'(e.error_code), int'(rsp_error_code));
            if (rsp_queue_length !== e.queue_length)
               note_mismatch("queue_length", int'(e.queue_length), int'(rsp_queue_length));
            if (rsp_resources_left !== e.resources_left)
               note_mismatch("resources_left", int'(e.resources_left),
                             int'(rsp_resources_left));
         end
      end
   end

   // Stimulus
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty window, grants by produce, ties, pushed-out entry
      write_resources(8'd0);
      queue_word(FUNC_REQUEST, 3, 32'd100);
      queue_word(FUNC_CONSUME, 3, 32'd0);
      queue_word(FUNC_PRODUCE, 0, 32'd0);
      queue_word(FUNC_CONSUME, 3, 32'd0);
      queue_word(FUNC_CONSUME, 3, 32'd0);
      queue_word(FUNC_REQUEST, 0, 32'h0000_0000);
      queue_word(FUNC_REQUEST, 15, 32'hFFFF_FFFF);
      queue_word(FUNC_REQUEST, 0, 32'd5);
      queue_word(FUNC_PRODUCE, 0, 32'd0);
      queue_word(FUNC_PRODUCE, 0, 32'd0);
      queue_word(FUNC_REQUEST, 5, 32'h0000_0000);
      queue_word(FUNC_CONSUME, 15, 32'd0);
      queue_word(FUNC_NONE, 15, 32'hFFFF_FFFF);
      queue_word(FUNC_CONSUME, 5, 32'd0);
      queue_word(FUNC_PRODUCE, 0, 32'd0);
      queue_word(FUNC_CONSUME, 15, 32'd0);
      queue_word(FUNC_CONSUME, 0, 32'd0);

      // directed: saturating produce
      write_resources(8'd254);
      queue_word(FUNC_PRODUCE, 0, 32'd0);
      queue_word(FUNC_PRODUCE, 7, 32'hFFFF_FFFF);
      queue_word(FUNC_REQUEST, 7, 32'h8000_0000);
      write_resources(8'd255);
      queue_word(FUNC_PRODUCE, 0, 32'd0);
      queue_word(FUNC_CONSUME, 7, 32'd0);

      // random phases over several window sizes and idle rates
      write_resources(8'd1);
      run_random(160, 0);
      write_resources(RES_W'($urandom_range(0, 4)));
      run_random(160, 59);
      write_resources(8'd2);
      run_random(160, 15);
      write_resources(RES_W'($urandom_range(0, 20)));
      run_random(170, 0);

      wait_idle();
      if (mismatch_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #4ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
